// ===== rtl/core/deadzone_camera_follow_unit_macros.svh =====
// Assertion macros for the dead-zone camera follower.
// Used by the top level in rtl/core; depends on nothing else.
`ifndef DEADZONE_CAMERA_FOLLOW_UNIT_MACROS_SVH
`define DEADZONE_CAMERA_FOLLOW_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DZCF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DZCF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	`DZCF_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`else
`define DZCF_ASSERT(lbl, clk, rstn, prop, msg)
`define DZCF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dzcf_pkg.sv =====
// Shared types and constants of the dead-zone camera follower.
// Depends on nothing; imported by dzcf_div and the top level.
`default_nettype none
package dzcf_pkg;

	localparam int FRAC_BITS = 8;
	localparam int POS_W     = 24;
	localparam int SIZE_W    = 15;
	localparam int SIZE_U_W  = SIZE_W + FRAC_BITS;
	localparam int HDIV_W    = SIZE_U_W + 11;
	localparam int CALC_W    = (SIZE_U_W + 2 > 27) ? SIZE_U_W + 2 : 27;
	localparam int MAG_W     = POS_W + 1;
	localparam int TERM_W    = 31;
	localparam int ALPHA_W   = 17;

	localparam int DIV_W     = 44;
	localparam int DIVR_W    = 24;
	localparam int DIV_CNT_W = 6;

	localparam logic [15:0]        UNITY_ZOOM = 16'd4096;
	localparam logic [TERM_W-1:0]  Q30_ONE    = 31'd1073741824;
	// exp(-1) in Q1.30 as the truncating 12-term series produces it.
	localparam logic [TERM_W-1:0]  EM1_Q30    = 31'd395007543;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
	localparam logic [3:0]         TAYLOR_TERMS = 4'd12;

	localparam logic [1:0] CFG_FOLLOW_TIME = 2'd0;
	localparam logic [1:0] CFG_DEAD_ZONE   = 2'd1;
	localparam logic [1:0] CFG_SCREEN_W    = 2'd2;
	localparam logic [1:0] CFG_SCREEN_H    = 2'd3;

	localparam logic [23:0]       RST_FOLLOW_TIME = 24'd120000;
	localparam logic [15:0]       RST_DEAD_ZONE   = 16'd19661;
	localparam logic [SIZE_W-1:0] RST_SCREEN_W    = 15'd1920;
	localparam logic [SIZE_W-1:0] RST_SCREEN_H    = 15'd1080;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVR_W-1:0]    divisor;
		logic [DIV_CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACHK,
		S_XDIV,
		S_TMUL,
		S_TDIV_GO,
		S_TDIV,
		S_PMUL,
		S_PUPD,
		S_HDIV_GO,
		S_HDIV,
		S_ZMUL,
		S_EXC,
		S_SMUL,
		S_UPD,
		S_CLAMP,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/dzcf_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on dzcf_pkg for the request and response types.
`default_nettype none
module dzcf_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dzcf_pkg::div_req_t req,
	output dzcf_pkg::div_rsp_t      rsp
);
	import dzcf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVR_W-1:0]    dvs_q;
	logic [DIVR_W:0]      trial;
	logic                 fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// Left-align the dividend so only its significant bits are walked.
			quo_q <= req.dividend << (DIV_CNT_W'(DIV_W) - req.nbits);
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIVR_W'(trial - {1'b0, dvs_q}) : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/deadzone_camera_follow_unit.sv =====
// Dead-zone camera follower top level; uses dzcf_pkg, dzcf_div and the macro header.
// A bypass or first frame goes straight to the done state, a saturated alpha skips the series,
// and otherwise the shared bit-serial divider sets how long a frame takes.
// Throughput: one item at a time; the input is not ready until the item has finished.
// Reset (arst_n low) clears the camera, the last timestamp and the valid flag at once,
// and loads the register defaults; there is no clearing pass.
`default_nettype none
`include "deadzone_camera_follow_unit_macros.svh"
module deadzone_camera_follow_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [23:0] cursor_x,
	input  wire logic signed [23:0] cursor_y,
	input  wire logic [15:0]        zoom_factor,
	input  wire logic [31:0]        time_us,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      anchor_x,
	output logic signed [23:0]      anchor_y,
	output logic                    bypass
);
	import dzcf_pkg::*;

	// The sequencer walks one frame through a shared divider and a shared
	// 32x32 multiplier. The order is: alpha from dt and tau (one divide, a
	// 12-term Taylor series with one multiply and one divide per term, then up
	// to 15 multiplies by exp(-1)), then each axis in turn (half extent by
	// divide, dead zone by multiply, step by multiply, then clamp).

	state_t state_q, state_d;

	// Configuration registers.
	logic [23:0]       tau_q;
	logic [15:0]       dzf_q;
	logic [SIZE_W-1:0] scr_w_q;
	logic [SIZE_W-1:0] scr_h_q;

	// Frame inputs held for the duration of the work.
	logic signed [POS_W-1:0] cur_x_q;
	logic signed [POS_W-1:0] cur_y_q;
	logic [15:0]             zoom_q;
	logic [31:0]             now_q;
	logic                    byp_q;

	// Follower state.
	logic signed [POS_W-1:0] cam_x_q;
	logic signed [POS_W-1:0] cam_y_q;
	logic [31:0]             last_q;
	logic                    cam_valid_q;

	// Alpha datapath.
	logic [31:0]         dt_q;
	logic [3:0]          k_q;
	logic [TERM_W-1:0]   f_q;
	logic [TERM_W-1:0]   term_q;
	logic signed [32:0]  sum_q;
	logic [3:0]          i_q;
	logic [TERM_W-1:0]   e_q;
	logic [3:0]          pcnt_q;
	logic [ALPHA_W-1:0]  alpha_q;

	// Axis datapath.
	logic                    ax_q;
	logic [SIZE_U_W-1:0]     half_q;
	logic signed [MAG_W-1:0] d_q;
	logic [MAG_W-1:0]        ex_q;
	logic signed [CALC_W-1:0] nc_q;
	logic [63:0]             prod_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [POS_W-1:0] anchor_x_q;
	logic signed [POS_W-1:0] anchor_y_q;
	logic                    bypass_q;

	// Shared units.
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	// Combinational helpers.
	logic                    in_xfer;
	logic                    out_free;
	logic                    alpha_sat;
	logic [SIZE_W-1:0]       size_px;
	logic [SIZE_U_W-1:0]     size_u;
	logic signed [POS_W-1:0] cam_cur;
	logic signed [POS_W-1:0] cur_cur;
	logic signed [32:0]      sum_nxt;
	logic [TERM_W-1:0]       e_shift;
	logic [SIZE_U_W-1:0]     zone;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        step;
	logic signed [CALC_W-1:0] half_s;
	logic signed [CALC_W-1:0] hi_s;
	logic                    clamp_en;
	logic signed [CALC_W-1:0] clamped;
	logic signed [POS_W-1:0] cam_new;

	dzcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign mul_p = mul_a * mul_b;

	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	// A dt of sixteen time constants or more leaves exp(-x) below one LSB.
	assign alpha_sat = (tau_q == '0) || (dt_q >= {4'd0, tau_q, 4'd0});
	assign size_px   = ax_q ? scr_h_q : scr_w_q;
	assign size_u    = {size_px, FRAC_BITS'(0)};
	assign cam_cur   = ax_q ? cam_y_q : cam_x_q;
	assign cur_cur   = ax_q ? cur_y_q : cur_x_q;
	assign sum_nxt   = i_q[0] ? sum_q - $signed({2'b00, div_rsp.quot[TERM_W-1:0]})
	                          : sum_q + $signed({2'b00, div_rsp.quot[TERM_W-1:0]});
	assign e_shift   = e_q >> 14;
	assign zone      = prod_q[16 +: SIZE_U_W];
	assign mag       = d_q[MAG_W-1] ? MAG_W'(-d_q) : MAG_W'(d_q);
	assign step      = prod_q[16 +: MAG_W];
	assign half_s    = $signed(CALC_W'(half_q));
	assign hi_s      = $signed(CALC_W'(size_u)) - half_s;
	assign clamp_en  = {1'b0, size_u} > {half_q, 1'b0};

	// Clamp to the screen when the view fits on it, then saturate to 24 bits.
	always_comb begin
		clamped = nc_q;
		if (clamp_en) begin
			if (clamped < half_s) begin
				clamped = half_s;
			end
			if (clamped > hi_s) begin
				clamped = hi_s;
			end
		end
		if (clamped > $signed(CALC_W'(2 ** (POS_W - 1) - 1))) begin
			cam_new = {1'b0, {(POS_W - 1){1'b1}}};
		end else if (clamped < -$signed(CALC_W'(2 ** (POS_W - 1)))) begin
			cam_new = {1'b1, {(POS_W - 1){1'b0}}};
		end else begin
			cam_new = clamped[POS_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (zoom_factor <= UNITY_ZOOM || !cam_valid_q) begin
						state_d = S_DONE;
					end else begin
						state_d = S_ACHK;
					end
				end
			end
			S_ACHK:    state_d = alpha_sat ? S_HDIV_GO : S_XDIV;
			S_XDIV:    if (div_rsp.done) state_d = S_TMUL;
			S_TMUL:    state_d = S_TDIV_GO;
			S_TDIV_GO: state_d = S_TDIV;
			S_TDIV: begin
				if (div_rsp.done) begin
					state_d = (i_q == TAYLOR_TERMS) ? S_PMUL : S_TMUL;
				end
			end
			S_PMUL:    state_d = (pcnt_q < k_q) ? S_PUPD : S_HDIV_GO;
			S_PUPD:    state_d = S_PMUL;
			S_HDIV_GO: state_d = S_HDIV;
			S_HDIV:    if (div_rsp.done) state_d = S_ZMUL;
			S_ZMUL:    state_d = S_EXC;
			S_EXC:     state_d = S_SMUL;
			S_SMUL:    state_d = S_UPD;
			S_UPD:     state_d = S_CLAMP;
			S_CLAMP:   state_d = ax_q ? S_DONE : S_HDIV_GO;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Control outputs: handshake, divider requests and multiplier operands.
	always_comb begin
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		div_req.nbits    = '0;
		mul_a            = '0;
		mul_b            = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_ACHK: begin
				// x = dt * 2^16 / tau; dt is below 2^28 on this path.
				div_req.start    = !alpha_sat;
				div_req.dividend = {dt_q[27:0], 16'd0};
				div_req.divisor  = tau_q;
				div_req.nbits    = DIV_CNT_W'(DIV_W);
			end
			S_TMUL: begin
				mul_a = 32'(term_q);
				mul_b = 32'(f_q);
			end
			S_TDIV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(prod_q[30 +: TERM_W]);
				div_req.divisor  = DIVR_W'(i_q);
				div_req.nbits    = DIV_CNT_W'(TERM_W);
			end
			S_PMUL: begin
				mul_a = 32'(e_q);
				mul_b = 32'(EM1_Q30);
			end
			S_HDIV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'({size_u, 11'd0});
				div_req.divisor  = DIVR_W'(zoom_q);
				div_req.nbits    = DIV_CNT_W'(HDIV_W);
			end
			S_ZMUL: begin
				mul_a = 32'(half_q);
				mul_b = 32'(dzf_q);
			end
			S_SMUL: begin
				mul_a = 32'(ex_q);
				mul_b = 32'(alpha_q);
			end
			S_XDIV, S_TDIV, S_PUPD, S_HDIV, S_EXC, S_UPD, S_CLAMP, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cam_valid_q <= 1'b0;
			cam_x_q     <= '0;
			cam_y_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			tau_q       <= RST_FOLLOW_TIME;
			dzf_q       <= RST_DEAD_ZONE;
			scr_w_q     <= RST_SCREEN_W;
			scr_h_q     <= RST_SCREEN_H;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FOLLOW_TIME: tau_q   <= cfg_data;
					CFG_DEAD_ZONE:   dzf_q   <= cfg_data[15:0];
					CFG_SCREEN_W:    scr_w_q <= cfg_data[SIZE_W-1:0];
					CFG_SCREEN_H:    scr_h_q <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && in_xfer && zoom_factor > UNITY_ZOOM
			    && !cam_valid_q) begin
				// First frame snaps onto the cursor without clamping.
				cam_x_q     <= cursor_x;
				cam_y_q     <= cursor_y;
				last_q      <= time_us;
				cam_valid_q <= 1'b1;
			end
			if (state_q == S_CLAMP) begin
				if (ax_q) begin
					cam_y_q <= cam_new;
					last_q  <= now_q;
				end else begin
					cam_x_q <= cam_new;
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cur_x_q <= cursor_x;
					cur_y_q <= cursor_y;
					zoom_q  <= zoom_factor;
					now_q   <= time_us;
					byp_q   <= zoom_factor <= UNITY_ZOOM;
					dt_q    <= time_us - last_q;
					ax_q    <= 1'b0;
				end
			end
			S_ACHK: begin
				alpha_q <= ALPHA_ONE;
			end
			S_XDIV: begin
				if (div_rsp.done) begin
					k_q    <= div_rsp.quot[19:16];
					f_q    <= {div_rsp.quot[15:0], 14'd0} & TERM_W'({1'b0, 30'h3FFFFFFF});
					term_q <= Q30_ONE;
					sum_q  <= 33'(Q30_ONE);
					i_q    <= 4'd1;
				end
			end
			S_TMUL: begin
				prod_q <= mul_p;
			end
			S_TDIV: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quot[TERM_W-1:0];
					sum_q  <= sum_nxt;
					i_q    <= i_q + 4'd1;
					e_q    <= sum_nxt[32] ? '0 : sum_nxt[TERM_W-1:0];
					pcnt_q <= '0;
				end
			end
			S_PMUL: begin
				prod_q <= mul_p;
				if (pcnt_q >= k_q) begin
					alpha_q <= ALPHA_ONE - ((e_shift > TERM_W'(ALPHA_ONE))
					           ? ALPHA_ONE : e_shift[ALPHA_W-1:0]);
				end
			end
			S_PUPD: begin
				e_q    <= prod_q[30 +: TERM_W];
				pcnt_q <= pcnt_q + 4'd1;
			end
			S_HDIV: begin
				if (div_rsp.done) begin
					half_q <= div_rsp.quot[SIZE_U_W-1:0];
				end
			end
			S_ZMUL: begin
				prod_q <= mul_p;
				d_q    <= MAG_W'(cur_cur) - MAG_W'(cam_cur);
			end
			S_EXC: begin
				ex_q <= (mag > MAG_W'(zone)) ? mag - MAG_W'(zone) : '0;
			end
			S_SMUL: begin
				prod_q <= mul_p;
			end
			S_UPD: begin
				// The step truncates toward zero, so it is applied by sign.
				nc_q <= d_q[MAG_W-1] ? CALC_W'(cam_cur) - $signed(CALC_W'(step))
				                     : CALC_W'(cam_cur) + $signed(CALC_W'(step));
			end
			S_CLAMP: begin
				ax_q <= 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					anchor_x_q <= cam_x_q;
					anchor_y_q <= cam_y_q;
					bypass_q   <= byp_q;
				end
			end
			S_TDIV_GO, S_HDIV_GO: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign anchor_x  = anchor_x_q;
	assign anchor_y  = anchor_y_q;
	assign bypass    = bypass_q;

	// The sequencer never issues a divide while the divider is still busy.
	`DZCF_ASSERT_IMPL(a_div_free, clk, arst_n, div_req.start, !div_rsp.busy, "divide issued while busy")
	// A new result appears only when a frame finishes.
	`DZCF_ASSERT_IMPL(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == S_DONE), "result without finished frame")
	// A bypass frame goes straight to completion and leaves the camera alone.
	`DZCF_ASSERT_IMPL(a_bypass_fast, clk, arst_n, in_xfer && zoom_factor <= UNITY_ZOOM, ##1 (state_q == S_DONE && byp_q && $stable(cam_x_q) && $stable(cam_y_q)), "bypass frame disturbed state")
	// Once the camera has snapped, it stays valid until reset.
	`DZCF_ASSERT(a_valid_sticky, clk, arst_n, !$fell(cam_valid_q), "camera valid flag dropped")

endmodule
`default_nettype wire
